// ===== src/ccw_pkg.sv =====
// Shared constants and types for the coin change way counter.
package ccw_pkg;

  localparam int MAX_SUM_DEF  = 65535;
  localparam int MAX_PART_DEF = 15;

  localparam int TARGET_W = 16;
  localparam int COUNT_W  = 64;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] MAX_PART_RESET = CFG_W'(1);

  typedef struct packed {
    logic rd_en;
    logic issue;
    logic clr_we;
    logic clr_one;
    logic load;
    logic zero_res;
  } ctl_t;

endpackage

// ===== src/ccw_table.sv =====
// Count table memory with one write port and two registered read ports.
module ccw_table #(
  parameter int DEPTH = ccw_pkg::MAX_SUM_DEF + 1,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = ccw_pkg::COUNT_W
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== src/ccw_upd.sv =====
// Shared adder stage that accumulates one table entry per cycle, with bypass.
module ccw_upd #(
  parameter int AW = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        issue,
  input  logic [AW-1:0]               addr_a,
  input  logic [AW-1:0]               addr_b,
  input  logic [ccw_pkg::COUNT_W-1:0] rd_data_a,
  input  logic [ccw_pkg::COUNT_W-1:0] rd_data_b,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [ccw_pkg::COUNT_W-1:0] wr_data
);

  logic                        issue_q;
  logic [AW-1:0]               addr_a_q;
  logic [AW-1:0]               addr_b_q;
  logic                        last_valid;
  logic [AW-1:0]               last_addr;
  logic [ccw_pkg::COUNT_W-1:0] last_data;
  logic [ccw_pkg::COUNT_W-1:0] oper_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_q    <= 1'b0;
      last_valid <= 1'b0;
    end else begin
      issue_q    <= issue;
      last_valid <= issue_q;
    end
  end

  always_ff @(posedge clk) begin
    addr_a_q  <= addr_a;
    addr_b_q  <= addr_b;
    last_addr <= addr_a_q;
    last_data <= wr_data;
  end

  // The entry written in the previous cycle was not yet visible to the read.
  always_comb begin
    if (last_valid && (last_addr == addr_b_q)) begin
      oper_b = last_data;
    end else begin
      oper_b = rd_data_b;
    end
  end

  assign wr_en   = issue_q;
  assign wr_addr = addr_a_q;
  assign wr_data = rd_data_a + oper_b;

endmodule

// ===== src/ccw_ctrl.sv =====
// Sequencer that clears the table, runs one pass per coin value and reads the result.
module ccw_ctrl #(
  parameter int MAX_SUM  = ccw_pkg::MAX_SUM_DEF,
  parameter int MAX_PART = ccw_pkg::MAX_PART_DEF,
  parameter int AW       = $clog2(MAX_SUM + 1),
  parameter int CW       = $clog2(MAX_PART + 2)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ccw_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ccw_pkg::TARGET_W-1:0] target_sum,
  input  logic                         out_free,
  output ccw_pkg::ctl_t                ctl,
  output logic [AW-1:0]                addr_a,
  output logic [AW-1:0]                addr_b
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_PICK  = 6'b000100,
    S_PASS  = 6'b001000,
    S_READ  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [ccw_pkg::CFG_W-1:0] max_part;
  logic [AW-1:0]             tgt;
  logic [AW-1:0]             tgt_next;
  logic [CW-1:0]             coins;
  logic [CW-1:0]             coins_next;
  logic [CW-1:0]             coin;
  logic [CW-1:0]             coin_next;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             idx_next;
  logic                      zero_res;
  logic                      zero_res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      max_part <= ccw_pkg::MAX_PART_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        max_part <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt      <= tgt_next;
    coins    <= coins_next;
    coin     <= coin_next;
    idx      <= idx_next;
    zero_res <= zero_res_next;
  end

  always_comb begin
    state_next    = state;
    tgt_next      = tgt;
    coins_next    = coins;
    coin_next     = coin;
    idx_next      = idx;
    zero_res_next = zero_res;
    ctl           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          tgt_next      = AW'(target_sum);
          zero_res_next = 32'(target_sum) > 32'(MAX_SUM);
          idx_next      = '0;
          if (32'(max_part) > 32'(MAX_PART)) begin
            coins_next = CW'(MAX_PART);
          end else begin
            coins_next = CW'(max_part);
          end
          if (32'(target_sum) > 32'(MAX_SUM)) begin
            state_next = S_WAIT;
          end else begin
            state_next = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        ctl.clr_we  = 1'b1;
        ctl.clr_one = (idx == '0);
        if (idx == tgt) begin
          coin_next  = CW'(1);
          state_next = S_PICK;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      S_PICK: begin
        if ((coin <= coins) && (32'(coin) <= 32'(tgt))) begin
          idx_next   = AW'(coin);
          state_next = S_PASS;
        end else begin
          state_next = S_READ;
        end
      end
      S_PASS: begin
        ctl.rd_en = 1'b1;
        ctl.issue = 1'b1;
        if (idx == tgt) begin
          coin_next  = coin + CW'(1);
          state_next = S_PICK;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      S_READ: begin
        ctl.rd_en  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        ctl.load     = out_free;
        ctl.zero_res = zero_res;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign addr_a   = (state == S_READ) ? tgt : idx;
  assign addr_b   = AW'(32'(idx) - 32'(coin));

endmodule

// ===== src/coin_change_way_counter.sv =====
// A target beyond the table size returns zero without running the table passes.
// In a coin pass the shared adder updates one table entry per cycle, and only one
// request is in flight.
// Reset clears the sequencer and output valid and sets max_part to 1; the table is
// not cleared, since every request rewrites the entries it reads.
module coin_change_way_counter #(
  parameter int MAX_SUM  = ccw_pkg::MAX_SUM_DEF,
  parameter int MAX_PART = ccw_pkg::MAX_PART_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ccw_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ccw_pkg::TARGET_W-1:0] target_sum,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ccw_pkg::COUNT_W-1:0]  way_count
);

  localparam int DEPTH = MAX_SUM + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_PART + 2);

  ccw_pkg::ctl_t               ctl;
  logic [AW-1:0]               addr_a;
  logic [AW-1:0]               addr_b;
  logic [ccw_pkg::COUNT_W-1:0] rd_data_a;
  logic [ccw_pkg::COUNT_W-1:0] rd_data_b;
  logic                        upd_we;
  logic [AW-1:0]               upd_addr;
  logic [ccw_pkg::COUNT_W-1:0] upd_data;
  logic                        tbl_we;
  logic [AW-1:0]               tbl_addr;
  logic [ccw_pkg::COUNT_W-1:0] tbl_data;
  logic                        out_free;

  assign out_free = !out_valid || !out_stall;

  ccw_ctrl #(
    .MAX_SUM  (MAX_SUM),
    .MAX_PART (MAX_PART),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .target_sum  (target_sum),
    .out_free    (out_free),
    .ctl         (ctl),
    .addr_a      (addr_a),
    .addr_b      (addr_b)
  );

  ccw_upd #(
    .AW (AW)
  ) u_upd (
    .clk       (clk),
    .rst       (rst),
    .issue     (ctl.issue),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (upd_we),
    .wr_addr   (upd_addr),
    .wr_data   (upd_data)
  );

  always_comb begin
    if (ctl.clr_we) begin
      tbl_we   = 1'b1;
      tbl_addr = addr_a;
      tbl_data = ctl.clr_one ? ccw_pkg::COUNT_W'(1) : '0;
    end else begin
      tbl_we   = upd_we;
      tbl_addr = upd_addr;
      tbl_data = upd_data;
    end
  end

  ccw_table #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (ccw_pkg::COUNT_W)
  ) u_table (
    .clk       (clk),
    .rd_en     (ctl.rd_en),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (tbl_we),
    .wr_addr   (tbl_addr),
    .wr_data   (tbl_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      way_count <= ctl.zero_res ? '0 : rd_data_a;
    end
  end

endmodule

// ===== src/ccw_checker.sv =====
// Port-level checks for the coin change way counter and their bind.
module ccw_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ccw_pkg::COUNT_W-1:0]  way_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(way_count))
    else $error("Stalled result changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Block took a second request while one was in flight.");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared while no request was in flight.");

  a_idle_has_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(in_stall) |-> out_valid)
    else $error("Block went idle without presenting its result.");

endmodule

bind coin_change_way_counter ccw_checker u_ccw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .way_count (way_count)
);
